### rtl/core/usd_pkg.sv
package usd_pkg;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } in_word_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        status;
        logic        last_of_run;
    } out_word_t;

    // One command per input word that causes results: err_count error results
    // first, then optionally one closing result.
    typedef struct packed {
        logic [2:0]  err_count;
        logic        has_tail;
        logic [20:0] tail_cp;
        logic        tail_err;
    } cmd_t;

    localparam logic [20:0] ERR_CP   = 21'h00FFFF;
    localparam logic [20:0] MIN_TWO   = 21'h000080;
    localparam logic [20:0] MIN_THREE = 21'h000800;
    localparam logic [20:0] MIN_FOUR  = 21'h010000;
    localparam logic [20:0] MAX_CP    = 21'h10FFFF;
    localparam logic [20:0] BMP_MAX   = 21'h00FFFF;

    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

endpackage

### rtl/core/utf8_stream_decoder.sv
// UTF-8 stream decoder.
// Input channel (s_valid/s_ready/s_payload): one raw byte per word, with an
// end_of_input flag on the last byte of a stream. Output channel
// (m_valid/m_ready/m_payload): one code point per word, status 1 with code
// point 0xFFFF for a malformed or unrepresentable sequence, and last_of_run
// set on the final word caused by a given input byte. Bytes that only extend
// a pending sequence cause no output word.
// cfg_wr_en/cfg_wr_data write ucs2_mode, which limits results to 16 bits;
// write it only while the decoder is idle.
// Throughput: one input byte per cycle while each byte causes at most one
// output word. A failed sequence gives up to four words, one per cycle from
// the emitter, and the input stalls once the two-entry command queue fills.
// Results pass the command queue, cur_reg and the output register.
// Reset (aresetn low, synchronous) drops any pending sequence, empties the
// queue and the output register, and clears ucs2_mode.
// When the receiver stalls, the output word holds, the queue fills, and
// s_ready falls; nothing is lost.
module utf8_stream_decoder (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  usd_pkg::in_word_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output usd_pkg::out_word_t m_payload
);

    logic          q_full, q_push, q_pop, q_valid;
    usd_pkg::cmd_t push_cmd, pop_cmd;

    usd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    usd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (pop_cmd)
    );

    usd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

### rtl/core/usd_front.sv
module usd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  usd_pkg::in_word_t s_payload,
    input  logic              q_full,
    output logic              q_push,
    output usd_pkg::cmd_t     q_cmd
);

    logic       ucs2_mode_reg;
    logic [7:0] seq_bytes_reg [3];
    logic [1:0] seq_count_reg, seq_count_next;
    logic [2:0] seq_length_reg, seq_length_next;

    logic [7:0]    b;
    logic          eoi;
    logic          cont;
    logic [2:0]    lead_len;
    logic [2:0]    count_up;
    logic [20:0]   cp;
    logic          ok;
    logic          byte_we;
    logic [1:0]    wr_idx;
    logic          accept;
    usd_pkg::cmd_t cmd;

    assign b       = s_payload.byte_in;
    assign eoi     = s_payload.end_of_input;
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cont     = (b & usd_pkg::CONT_MASK) == usd_pkg::CONT_TAG;
        count_up = {1'b0, seq_count_reg} + 3'd1;
        lead_len = usd_pkg::LEN_NONE;
        if (b[7:5] == 3'b110) begin
            lead_len = usd_pkg::LEN_TWO;
        end else if (b[7:4] == 4'b1110) begin
            lead_len = usd_pkg::LEN_THREE;
        end else if (b[7:3] == 5'b11110) begin
            lead_len = usd_pkg::LEN_FOUR;
        end

        cp              = '0;
        ok              = 1'b0;
        cmd             = '0;
        byte_we         = 1'b0;
        wr_idx          = seq_count_reg;
        seq_count_next  = seq_count_reg;
        seq_length_next = seq_length_reg;

        if (seq_count_reg != 2'd0 && cont) begin
            if (count_up >= seq_length_reg) begin
                unique case (seq_length_reg)
                    usd_pkg::LEN_THREE: begin
                        cp = {5'd0, seq_bytes_reg[0][3:0], seq_bytes_reg[1][5:0], b[5:0]};
                        ok = cp >= usd_pkg::MIN_THREE;
                    end
                    usd_pkg::LEN_FOUR: begin
                        cp = {seq_bytes_reg[0][2:0], seq_bytes_reg[1][5:0],
                              seq_bytes_reg[2][5:0], b[5:0]};
                        ok = cp >= usd_pkg::MIN_FOUR && cp <= usd_pkg::MAX_CP;
                    end
                    default: begin
                        cp = {10'd0, seq_bytes_reg[0][4:0], b[5:0]};
                        ok = cp >= usd_pkg::MIN_TWO;
                    end
                endcase
                if (ok) begin
                    cmd.has_tail = 1'b1;
                    if (ucs2_mode_reg && cp > usd_pkg::BMP_MAX) begin
                        cmd.tail_cp  = usd_pkg::ERR_CP;
                        cmd.tail_err = 1'b1;
                    end else begin
                        cmd.tail_cp = cp;
                    end
                end else begin
                    cmd.err_count = count_up;
                end
                seq_count_next  = 2'd0;
                seq_length_next = usd_pkg::LEN_NONE;
            end else begin
                byte_we        = 1'b1;
                seq_count_next = count_up[1:0];
                if (eoi) begin
                    cmd.err_count   = count_up;
                    seq_count_next  = 2'd0;
                    seq_length_next = usd_pkg::LEN_NONE;
                end
            end
        end else begin
            // Any pending sequence is broken: flush it, then treat b as a lead.
            cmd.err_count   = {1'b0, seq_count_reg};
            seq_count_next  = 2'd0;
            seq_length_next = usd_pkg::LEN_NONE;
            if (!b[7]) begin
                cmd.has_tail = 1'b1;
                cmd.tail_cp  = {13'd0, b};
            end else if (lead_len == usd_pkg::LEN_NONE || eoi) begin
                cmd.has_tail = 1'b1;
                cmd.tail_cp  = usd_pkg::ERR_CP;
                cmd.tail_err = 1'b1;
            end else begin
                byte_we         = 1'b1;
                wr_idx          = 2'd0;
                seq_count_next  = 2'd1;
                seq_length_next = lead_len;
            end
        end
    end

    assign q_cmd  = cmd;
    assign q_push = accept && (cmd.has_tail || cmd.err_count != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ucs2_mode_reg  <= 1'b0;
            seq_count_reg  <= 2'd0;
            seq_length_reg <= usd_pkg::LEN_NONE;
        end else begin
            if (cfg_wr_en) begin
                ucs2_mode_reg <= cfg_wr_data;
            end
            if (accept) begin
                seq_count_reg  <= seq_count_next;
                seq_length_reg <= seq_length_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && byte_we) begin
            seq_bytes_reg[wr_idx] <= b;
        end
    end

endmodule

### rtl/core/usd_queue.sv
module usd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  usd_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output usd_pkg::cmd_t pop_cmd
);

    usd_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = count_reg == 2'd2;
    assign pop_valid = count_reg != 2'd0;
    assign pop_cmd   = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/core/usd_back.sv
module usd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  usd_pkg::cmd_t      q_cmd,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output usd_pkg::out_word_t m_payload
);

    logic               cur_valid_reg;
    usd_pkg::cmd_t      cur_reg;
    logic               m_valid_reg;
    usd_pkg::out_word_t m_payload_reg;

    logic out_free, emit, emit_err, emit_last, load;

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = cur_valid_reg && out_free;
    assign emit_err  = cur_reg.err_count != 3'd0;
    assign emit_last = emit_err ? (cur_reg.err_count == 3'd1 && !cur_reg.has_tail) : 1'b1;
    // The next command moves in as the current one gives its last word.
    assign load      = q_valid && (!cur_valid_reg || (emit && emit_last));
    assign q_pop     = load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (load) begin
                cur_valid_reg <= 1'b1;
            end else if (emit && emit_last) begin
                cur_valid_reg <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg <= q_cmd;
        end else if (emit && emit_err) begin
            cur_reg.err_count <= cur_reg.err_count - 3'd1;
        end
        if (emit) begin
            m_payload_reg.code_point  <= emit_err ? usd_pkg::ERR_CP : cur_reg.tail_cp;
            m_payload_reg.status      <= emit_err ? 1'b1 : cur_reg.tail_err;
            m_payload_reg.last_of_run <= emit_last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

### rtl/core/usd_checker.sv
module usd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input usd_pkg::out_word_t m_payload
);

    // A stalled output word stays in place.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("output word changed while stalled");

    // Error words always carry the error value ERR_CP (0xFFFF).
    a_err_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status |-> m_payload.code_point == usd_pkg::ERR_CP)
        else $error("error word without replacement value");

    // Valid words never exceed the Unicode range.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.status |-> m_payload.code_point <= usd_pkg::MAX_CP)
        else $error("valid word outside the code point range");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind utf8_stream_decoder usd_checker u_usd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

### bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_TICKS = 6;
    localparam int DRAIN_TICKS  = 10;
    localparam int PHASE_WORDS  = 140;
    localparam int HOLD_AFTER   = 120;
    localparam int HOLD_TICKS   = 300;

    typedef struct {
        logic [7:0]  b;
        logic        eoi;
        bit          typed;
        logic [20:0] cp;
        logic        st;
    } row_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic               cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    usd_pkg::in_word_t  s_payload;
    logic               m_valid;
    logic               m_ready;
    usd_pkg::out_word_t m_payload;

    // Shadow of the decoder: pending sequence and the mode register.
    logic [7:0] pend_bytes [3];
    logic [1:0] pend_count = 2'd0;
    logic [2:0] pend_len   = usd_pkg::LEN_NONE;
    logic       ucs2_on    = 1'b0;

    usd_pkg::out_word_t step_cps [$];
    usd_pkg::out_word_t cp_expect_q [$];
    usd_pkg::in_word_t  stream_q [$];

    int  mismatches = 0;
    int  cycles     = 0;
    int  rx_seen    = 0;
    bit  tx_burst   = 1'b0;
    bit  rx_burst   = 1'b0;
    bit  hold_done  = 1'b0;

    row_t dir_rows [28] = '{
        '{8'h00, 1'b0, 1'b1, 21'h000000,      1'b0},
        '{8'h7F, 1'b0, 1'b1, 21'h00007F,      1'b0},
        '{8'h80, 1'b0, 1'b1, usd_pkg::ERR_CP, 1'b1},
        '{8'hFF, 1'b0, 1'b1, usd_pkg::ERR_CP, 1'b1},
        '{8'hC2, 1'b1, 1'b1, usd_pkg::ERR_CP, 1'b1},
        '{8'hC2, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'hC0, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'hE0, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'hA0, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'hED, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'hA0, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'hE1, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'h41, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'hE1, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'h80, 1'b1, 1'b0, 21'h0, 1'b0},
        '{8'hF4, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'h8F, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'hF4, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'h90, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0}
    };

    utf8_stream_decoder i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic void emit_cp(logic [20:0] cp, logic st);
        usd_pkg::out_word_t r;
        r.code_point  = cp;
        r.status      = st;
        r.last_of_run = 1'b0;
        step_cps.push_back(r);
    endfunction

    function automatic void emit_errors(int k);
        for (int i = 0; i < k; i++) emit_cp(usd_pkg::ERR_CP, 1'b1);
    endfunction

    // Works out the code points that one accepted word causes and advances the
    // shadow state.
    function automatic void decode_byte(usd_pkg::in_word_t w);
        logic [7:0]         b;
        logic [20:0]        cp;
        logic               ok;
        logic [2:0]         lead_len;
        bit                 handled;
        usd_pkg::out_word_t r;
        b = w.byte_in;
        handled = 1'b0;
        step_cps.delete();
        if (pend_count != 2'd0) begin
            if ((b & usd_pkg::CONT_MASK) == usd_pkg::CONT_TAG) begin
                handled = 1'b1;
                if (int'(pend_count) + 1 >= int'(pend_len)) begin
                    if (pend_len <= usd_pkg::LEN_TWO) begin
                        cp = {10'd0, pend_bytes[0][4:0], b[5:0]};
                        ok = (cp >= usd_pkg::MIN_TWO) && (cp < usd_pkg::MIN_THREE);
                    end else if (pend_len == usd_pkg::LEN_THREE) begin
                        cp = {5'd0, pend_bytes[0][3:0], pend_bytes[1][5:0], b[5:0]};
                        ok = (cp >= usd_pkg::MIN_THREE) && (cp < usd_pkg::MIN_FOUR);
                    end else begin
                        cp = {pend_bytes[0][2:0], pend_bytes[1][5:0], pend_bytes[2][5:0],
                              b[5:0]};
                        ok = (cp >= usd_pkg::MIN_FOUR) && (cp <= usd_pkg::MAX_CP);
                    end
                    if (!ok) emit_errors(int'(pend_count) + 1);
                    else if (ucs2_on && cp > usd_pkg::BMP_MAX) emit_cp(usd_pkg::ERR_CP, 1'b1);
                    else emit_cp(cp, 1'b0);
                    pend_count = 2'd0;
                    pend_len   = usd_pkg::LEN_NONE;
                end else begin
                    pend_bytes[pend_count] = b;
                    pend_count = pend_count + 2'd1;
                    if (w.end_of_input) begin
                        emit_errors(int'(pend_count));
                        pend_count = 2'd0;
                        pend_len   = usd_pkg::LEN_NONE;
                    end
                end
            end else begin
                // The breaking byte is taken again as a fresh lead below.
                emit_errors(int'(pend_count));
                pend_count = 2'd0;
                pend_len   = usd_pkg::LEN_NONE;
            end
        end
        if (!handled) begin
            if (b < 8'h80) begin
                emit_cp({13'd0, b}, 1'b0);
            end else begin
                casez (b)
                    8'b110?????: lead_len = usd_pkg::LEN_TWO;
                    8'b1110????: lead_len = usd_pkg::LEN_THREE;
                    8'b11110???: lead_len = usd_pkg::LEN_FOUR;
                    default:     lead_len = usd_pkg::LEN_NONE;
                endcase
                if (lead_len == usd_pkg::LEN_NONE || w.end_of_input) begin
                    emit_cp(usd_pkg::ERR_CP, 1'b1);
                end else begin
                    pend_bytes[0] = b;
                    pend_count    = 2'd1;
                    pend_len      = lead_len;
                end
            end
        end
        if (step_cps.size() > 0) begin
            r = step_cps.pop_back();
            r.last_of_run = 1'b1;
            step_cps.push_back(r);
        end
    endfunction

    // Appends one character's worth of bytes: mostly well-formed sequences,
    // some malformed (overlong, out of range, truncated, corrupted), some noise.
    function automatic void add_chunk();
        int                kind;
        int                len;
        int                keep;
        logic [20:0]       cp;
        logic [7:0]        seq [4];
        usd_pkg::in_word_t w;
        kind = $urandom_range(0, 99);
        if (kind >= 85) begin
            w.byte_in      = 8'($urandom());
            w.end_of_input = ($urandom_range(0, 15) == 0);
            stream_q.push_back(w);
            return;
        end
        if (kind < 60) begin
            len = $urandom_range(1, 4);
            case (len)
                1:       cp = 21'($urandom_range(0, 'h7F));
                2:       cp = 21'($urandom_range('h80, 'h7FF));
                3:       cp = 21'($urandom_range('h800, 'hFFFF));
                default: cp = 21'($urandom_range('h10000, 'h10FFFF));
            endcase
        end else begin
            len = $urandom_range(2, 4);
            case ($urandom_range(0, 3))
                0:       cp = 21'($urandom() & 'h7F);
                1:       cp = 21'($urandom() & 'h7FF);
                2:       cp = 21'($urandom() & 'hFFFF);
                default: cp = 21'($urandom());
            endcase
        end
        case (len)
            1: seq[0] = {1'b0, cp[6:0]};
            2: begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        keep = len;
        if (kind >= 60) begin
            keep = $urandom_range(1, len);
            if ($urandom_range(0, 1) == 1) seq[$urandom_range(1, len - 1)] = 8'($urandom());
        end
        for (int i = 0; i < keep; i++) begin
            w.byte_in      = seq[i];
            w.end_of_input = ($urandom_range(0, 15) == 0);
            stream_q.push_back(w);
        end
    endfunction

    // Offers one word after a random gap and returns at the edge that takes it.
    task automatic send_word(usd_pkg::in_word_t w);
        int gap;
        if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic set_mode(logic m);
        while (cp_expect_q.size() != 0) @(posedge aclk);
        // A buffered byte may still be in flight after the last result.
        repeat (SETTLE_TICKS) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        ucs2_on = m;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random_phase();
        usd_pkg::in_word_t w;
        while (stream_q.size() < PHASE_WORDS) add_chunk();
        // Flush any open sequence so the decoder ends the phase idle.
        w = stream_q.pop_back();
        w.end_of_input = 1'b1;
        stream_q.push_back(w);
        while (stream_q.size() > 0) begin
            w = stream_q.pop_front();
            send_word(w);
            decode_byte(w);
            foreach (step_cps[i]) cp_expect_q.push_back(step_cps[i]);
        end
        s_valid <= 1'b0;
    endtask

    task automatic check_word(usd_pkg::out_word_t got);
        usd_pkg::out_word_t want;
        if (cp_expect_q.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, got);
            mismatches++;
        end else begin
            want = cp_expect_q.pop_front();
            if (got.code_point !== want.code_point) begin
                $display("%0t: code_point expected %h, actual %h", $time,
                         want.code_point, got.code_point);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %b, actual %b", $time, want.status, got.status);
                mismatches++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $display("%0t: last_of_run expected %b, actual %b", $time,
                         want.last_of_run, got.last_of_run);
                mismatches++;
            end
        end
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        s_valid     <= 1'b0;
        s_payload   <= '0;
        m_ready     <= 1'b0;
    end

    // Receiver: random stalls per word, plus one long hold so the decoder
    // backs up and drops s_ready while the sender keeps offering.
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 19);
            if (!hold_done && rx_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                stall     = HOLD_TICKS;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            rx_seen++;
            check_word(m_payload);
        end
    end

    initial begin
        usd_pkg::in_word_t  w;
        usd_pkg::out_word_t r;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_mode(1'b0);

        foreach (dir_rows[i]) begin
            w.byte_in      = dir_rows[i].b;
            w.end_of_input = dir_rows[i].eoi;
            send_word(w);
            decode_byte(w);
            if (dir_rows[i].typed) begin
                r.code_point  = dir_rows[i].cp;
                r.status      = dir_rows[i].st;
                r.last_of_run = 1'b1;
                cp_expect_q.push_back(r);
            end else begin
                foreach (step_cps[k]) cp_expect_q.push_back(step_cps[k]);
            end
        end
        s_valid <= 1'b0;

        set_mode(1'b1);
        run_random_phase();
        set_mode(1'b0);
        run_random_phase();
        set_mode(1'b1);
        run_random_phase();

        while (cp_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_TICKS) @(posedge aclk);
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
